// ===== rtl/sfc_pkg.sv =====
// Shared types, constants and name tables for the STOMP frame checker.
// No dependencies.
`timescale 1ns / 1ps
package sfc_pkg;

  localparam int NUM_CMDS = 15;
  localparam int NUM_HDRS = 19;
  localparam int NAME_BYTES = 16;
  localparam int POS_W = 5;
  localparam logic [15:0] COUNT_CAP = 16'hFFFF;
  localparam int HDR_CL = 2;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [2:0] {
    PH_CMD, PH_LINE, PH_NAME, PH_VFIRST, PH_VALUE, PH_BODY, PH_DEAD
  } phase_t;

  typedef enum logic [2:0] {
    LP_IDLE, LP_SKIP, LP_PLUS, LP_MINUS, LP_DPOS, LP_DNEG, LP_DONE, LP_BAD
  } lp_t;

  localparam logic [3:0] E_OK        = 4'd0;
  localparam logic [3:0] E_NO_DATA   = 4'd1;
  localparam logic [3:0] E_NO_CMD    = 4'd2;
  localparam logic [3:0] E_NO_NULL   = 4'd3;
  localparam logic [3:0] E_NO_NL     = 4'd4;
  localparam logic [3:0] E_NO_BODYNL = 4'd5;
  localparam logic [3:0] E_BAD_CMD   = 4'd6;
  localparam logic [3:0] E_NO_HNAME  = 4'd7;
  localparam logic [3:0] E_NO_HVAL   = 4'd8;
  localparam logic [3:0] E_NO_LASTNL = 4'd9;
  localparam logic [3:0] E_EMPTY_VAL = 4'd10;
  localparam logic [3:0] E_BAD_HDR   = 4'd11;
  localparam logic [3:0] E_JUNK      = 4'd12;
  localparam logic [3:0] E_BAD_LEN   = 4'd13;
  localparam logic [3:0] E_LEN_MISM  = 4'd14;
  localparam logic [3:0] E_MISS_REQ  = 4'd15;

  typedef logic [NAME_BYTES*8-1:0] name_t;

  function automatic name_t cmd_name(input int i);
    unique case (i)
      0: cmd_name = name_t'("ABORT");
      1: cmd_name = name_t'("ACK");
      2: cmd_name = name_t'("BEGIN");
      3: cmd_name = name_t'("COMMIT");
      4: cmd_name = name_t'("CONNECT");
      5: cmd_name = name_t'("CONNECTED");
      6: cmd_name = name_t'("DISCONNECT");
      7: cmd_name = name_t'("ERROR");
      8: cmd_name = name_t'("MESSAGE");
      9: cmd_name = name_t'("NACK");
      10: cmd_name = name_t'("RECEIPT");
      11: cmd_name = name_t'("SEND");
      12: cmd_name = name_t'("STOMP");
      13: cmd_name = name_t'("SUBSCRIBE");
      default: cmd_name = name_t'("UNSUBSCRIBE");
    endcase
  endfunction

  function automatic logic [4:0] cmd_len(input int i);
    unique case (i)
      0, 2, 7, 12: cmd_len = 5'd5;
      1: cmd_len = 5'd3;
      3: cmd_len = 5'd6;
      4, 8, 10: cmd_len = 5'd7;
      5, 13: cmd_len = 5'd9;
      6: cmd_len = 5'd10;
      9, 11: cmd_len = 5'd4;
      default: cmd_len = 5'd11;
    endcase
  endfunction

  function automatic name_t hdr_name(input int i);
    unique case (i)
      0: hdr_name = name_t'("accept-version");
      1: hdr_name = name_t'("ack");
      2: hdr_name = name_t'("content-length");
      3: hdr_name = name_t'("content-type");
      4: hdr_name = name_t'("destination");
      5: hdr_name = name_t'("heart-beat");
      6: hdr_name = name_t'("host");
      7: hdr_name = name_t'("id");
      8: hdr_name = name_t'("login");
      9: hdr_name = name_t'("message");
      10: hdr_name = name_t'("message-id");
      11: hdr_name = name_t'("passcode");
      12: hdr_name = name_t'("receipt");
      13: hdr_name = name_t'("receipt-id");
      14: hdr_name = name_t'("session");
      15: hdr_name = name_t'("server");
      16: hdr_name = name_t'("subscription");
      17: hdr_name = name_t'("transaction");
      default: hdr_name = name_t'("version");
    endcase
  endfunction

  function automatic logic [4:0] hdr_len(input int i);
    unique case (i)
      0, 2: hdr_len = 5'd14;
      1: hdr_len = 5'd3;
      3, 16: hdr_len = 5'd12;
      4, 17: hdr_len = 5'd11;
      5, 10, 13: hdr_len = 5'd10;
      6: hdr_len = 5'd4;
      7: hdr_len = 5'd2;
      8: hdr_len = 5'd5;
      9, 12, 14, 18: hdr_len = 5'd7;
      11: hdr_len = 5'd8;
      default: hdr_len = 5'd6;
    endcase
  endfunction

  // character at position p of a right-aligned string, or zero past its length
  function automatic logic [7:0] name_char(input name_t s, input logic [4:0] len,
                                           input logic [4:0] p);
    logic [7:0] c;
    c = 8'h00;
    if (p < len) c = s[(int'(len) - 1 - int'(p))*8 +: 8];
    return c;
  endfunction

  function automatic logic [18:0] required_mask(input logic [3:0] cmd);
    logic [18:0] m;
    m = '0;
    unique case (cmd)
      4'd1, 4'd3, 4'd4: m[17] = 1'b1;
      4'd2, 4'd10, 4'd15: m[7] = 1'b1;
      4'd5: begin m[0] = 1'b1; m[6] = 1'b1; end
      4'd6: m[18] = 1'b1;
      4'd9: begin m[4] = 1'b1; m[10] = 1'b1; m[16] = 1'b1; end
      4'd11: m[13] = 1'b1;
      4'd12: m[4] = 1'b1;
      4'd14: begin m[4] = 1'b1; m[7] = 1'b1; end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/sfc_lenconv.sv =====
// Content-length decimal conversion, one byte per cycle while step is high.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
module sfc_lenconv (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic         clear,
  input  logic         start,
  input  logic [7:0]   data_byte,
  output sfc_pkg::lp_t state_o,
  output logic [31:0]  value_o
);
  sfc_pkg::lp_t st_r, st_nxt;
  logic [31:0] val_r, val_nxt;
  logic dig, sp;
  logic [3:0] d;
  logic [35:0] acc;
  logic [35:0] lim;

  assign state_o = st_r;
  assign value_o = val_r;

  always_comb begin
    dig = data_byte >= 8'h30 && data_byte <= 8'h39;
    d = data_byte[3:0];
    sp = data_byte == 8'h20 || (data_byte >= 8'h09 && data_byte <= 8'h0D);
    acc = {val_r, 3'b000} + {2'b00, val_r, 1'b0} + {32'd0, d};
    lim = (st_r == sfc_pkg::LP_DNEG) ? 36'd2147483648 : 36'd2147483647;
    st_nxt = st_r;
    val_nxt = val_r;
    if (step) begin
      case (st_r)
        sfc_pkg::LP_SKIP: begin
          if (sp) st_nxt = st_r;
          else if (data_byte == 8'h2B) st_nxt = sfc_pkg::LP_PLUS;
          else if (data_byte == 8'h2D) st_nxt = sfc_pkg::LP_MINUS;
          else if (dig) begin val_nxt = {28'd0, d}; st_nxt = sfc_pkg::LP_DPOS; end
          else st_nxt = sfc_pkg::LP_BAD;
        end
        sfc_pkg::LP_PLUS, sfc_pkg::LP_MINUS: begin
          if (dig) begin
            val_nxt = {28'd0, d};
            st_nxt = (st_r == sfc_pkg::LP_PLUS) ? sfc_pkg::LP_DPOS : sfc_pkg::LP_DNEG;
          end else st_nxt = sfc_pkg::LP_BAD;
        end
        sfc_pkg::LP_DPOS, sfc_pkg::LP_DNEG: begin
          if (dig) begin
            if (acc > lim) st_nxt = sfc_pkg::LP_BAD;
            else val_nxt = acc[31:0];
          end else begin
            if (st_r == sfc_pkg::LP_DNEG && val_r != 32'd0) val_nxt = 32'hFFFFFFFF;
            st_nxt = sfc_pkg::LP_DONE;
          end
        end
        default: st_nxt = st_r;
      endcase
    end
    if (start) st_nxt = sfc_pkg::LP_SKIP;
    if (clear) begin
      st_nxt = sfc_pkg::LP_IDLE;
      val_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sfc_pkg::LP_IDLE;
      val_r <= '0;
    end else begin
      st_r <= st_nxt;
      val_r <= val_nxt;
    end
  end
endmodule

// ===== rtl/stomp_frame_checker.sv =====
// STOMP frame checker top level: frame state, name matching and verdict.
// Depends on sfc_pkg and sfc_lenconv.
`timescale 1ns / 1ps
// Takes one frame byte per cycle (in_data_byte, in_last_byte) or an empty-frame
// marker, and gives one verdict per frame in the cycle after its last byte or
// its empty-frame marker. Per-byte work is the parallel compare of the byte
// against every name table entry. A registered output stage holds a waiting
// verdict; input stalls only when a verdict is waiting and not taken. Only the
// first content-length value is converted; counts saturate at 65535.
module stomp_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        in_empty_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_error_code,
  output logic [3:0]  out_command_code,
  output logic [18:0] out_header_mask,
  output logic [15:0] out_body_length
);
  localparam int NC = sfc_pkg::NUM_CMDS;
  localparam int NH = sfc_pkg::NUM_HDRS;

  sfc_pkg::phase_t ph_r, ph_nxt;
  logic [15:0] idx_r, idx_nxt, body_r, body_nxt;
  logic prevnl_r, sawnl_r, dblnl_r, firstnl_r, early_r;
  logic prevnl_nxt, sawnl_nxt, dblnl_nxt, firstnl_nxt, early_nxt;
  logic [NH-1:0] cand_r, cand_nxt;
  logic [sfc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [3:0] cmd_r, cmd_nxt, lerr_r, lerr_nxt;
  logic [18:0] seen_r, seen_nxt;

  logic ov_r;
  logic [3:0] oerr_r, ocmd_r;
  logic [18:0] omask_r;
  logic [15:0] olen_r;

  logic acc_in, is_nl, frame_end, lp_step, lp_start;
  logic [7:0] b;
  sfc_pkg::lp_t lp_st;
  logic [31:0] lp_val;
  logic [NC-1:0] cmd_bm, cmd_em;
  logic [NH-1:0] hdr_bm, hdr_em, hdr_first;
  logic [3:0] err, cmd_pick;
  logic [18:0] omask;
  logic [15:0] olen;
  logic lp_ok;
  logic [31:0] lp_fin;

  assign in_ready = !ov_r || out_ready;
  assign acc_in = in_valid && in_ready;
  assign b = in_data_byte;
  assign is_nl = b == sfc_pkg::CH_NL;
  assign frame_end = acc_in && (in_empty_frame || in_last_byte);
  assign lp_step = acc_in && !in_empty_frame &&
                   (lp_st == sfc_pkg::LP_SKIP || lp_st == sfc_pkg::LP_PLUS ||
                    lp_st == sfc_pkg::LP_MINUS || lp_st == sfc_pkg::LP_DPOS ||
                    lp_st == sfc_pkg::LP_DNEG);

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      cmd_bm[i] = pos_r < 5'(sfc_pkg::NAME_BYTES) &&
                  pos_r < sfc_pkg::cmd_len(i) &&
                  sfc_pkg::name_char(sfc_pkg::cmd_name(i), sfc_pkg::cmd_len(i), pos_r) == b;
      cmd_em[i] = sfc_pkg::cmd_len(i) == pos_r;
    end
    for (int i = 0; i < NH; i++) begin
      hdr_bm[i] = pos_r < 5'(sfc_pkg::NAME_BYTES) &&
                  pos_r < sfc_pkg::hdr_len(i) &&
                  sfc_pkg::name_char(sfc_pkg::hdr_name(i), sfc_pkg::hdr_len(i), pos_r) == b;
      hdr_em[i] = sfc_pkg::hdr_len(i) == pos_r;
      hdr_first[i] = sfc_pkg::hdr_len(i) != 5'd0 &&
                     sfc_pkg::name_char(sfc_pkg::hdr_name(i), sfc_pkg::hdr_len(i), 5'd0) == b;
    end
    cmd_pick = 4'd0;
    for (int i = NC - 1; i >= 0; i--)
      if (cand_r[i] && cmd_em[i]) cmd_pick = 4'(i + 1);
  end

  always_comb begin
    ph_nxt = ph_r; cand_nxt = cand_r; pos_nxt = pos_r; cmd_nxt = cmd_r;
    lerr_nxt = lerr_r; seen_nxt = seen_r; body_nxt = body_r; lp_start = 1'b0;
    firstnl_nxt = firstnl_r || (idx_r == 16'd0 && is_nl);
    dblnl_nxt = dblnl_r || (is_nl && prevnl_r);
    sawnl_nxt = sawnl_r || is_nl;
    prevnl_nxt = is_nl;
    early_nxt = early_r || (b == sfc_pkg::CH_NUL && !in_last_byte);
    idx_nxt = (idx_r < sfc_pkg::COUNT_CAP) ? idx_r + 16'd1 : idx_r;
    unique case (ph_r)
      sfc_pkg::PH_CMD: begin
        if (is_nl) begin
          if ((cand_r[NC-1:0] & cmd_em) == '0) begin
            cand_nxt = '0; lerr_nxt = sfc_pkg::E_BAD_CMD; ph_nxt = sfc_pkg::PH_DEAD;
          end else begin
            cand_nxt = {4'd0, cand_r[NC-1:0] & cmd_em};
            cmd_nxt = cmd_pick; ph_nxt = sfc_pkg::PH_LINE;
          end
        end else if (pos_r < 5'(sfc_pkg::NAME_BYTES)) begin
          cand_nxt = {4'd0, cand_r[NC-1:0] & cmd_bm};
          pos_nxt = pos_r + 5'd1;
        end else cand_nxt = '0;
      end
      sfc_pkg::PH_LINE: begin
        if (is_nl) ph_nxt = sfc_pkg::PH_BODY;
        else if (b == sfc_pkg::CH_COLON) begin
          lerr_nxt = sfc_pkg::E_NO_HNAME; ph_nxt = sfc_pkg::PH_DEAD;
        end else if (b == sfc_pkg::CH_NUL) begin
          lerr_nxt = sfc_pkg::E_NO_BODYNL; ph_nxt = sfc_pkg::PH_DEAD;
        end else begin
          cand_nxt = hdr_first; pos_nxt = 5'd1; ph_nxt = sfc_pkg::PH_NAME;
        end
      end
      sfc_pkg::PH_NAME: begin
        if (is_nl) begin
          lerr_nxt = sfc_pkg::E_NO_HVAL; ph_nxt = sfc_pkg::PH_DEAD;
        end else if (b == sfc_pkg::CH_COLON) begin
          cand_nxt = cand_r & hdr_em;
          if (cand_r[sfc_pkg::HDR_CL] && hdr_em[sfc_pkg::HDR_CL] &&
              lp_st == sfc_pkg::LP_IDLE) lp_start = 1'b1;
          ph_nxt = sfc_pkg::PH_VFIRST;
        end else if (pos_r < 5'(sfc_pkg::NAME_BYTES)) begin
          cand_nxt = cand_r & hdr_bm; pos_nxt = pos_r + 5'd1;
        end else cand_nxt = '0;
      end
      sfc_pkg::PH_VFIRST: begin
        if (is_nl) begin
          lerr_nxt = sfc_pkg::E_EMPTY_VAL; ph_nxt = sfc_pkg::PH_DEAD;
        end else ph_nxt = sfc_pkg::PH_VALUE;
      end
      sfc_pkg::PH_VALUE: begin
        if (is_nl) begin
          if (cand_r == '0) begin
            lerr_nxt = sfc_pkg::E_BAD_HDR; ph_nxt = sfc_pkg::PH_DEAD;
          end else begin
            seen_nxt = seen_r | cand_r; ph_nxt = sfc_pkg::PH_LINE;
          end
        end
      end
      sfc_pkg::PH_BODY: begin
        if (!in_last_byte && body_r < sfc_pkg::COUNT_CAP) body_nxt = body_r + 16'd1;
      end
      default: ph_nxt = ph_r;
    endcase
  end

  // verdict on the frame's final byte, from current state and this byte
  always_comb begin
    err = sfc_pkg::E_OK; omask = '0; olen = '0;
    lp_ok = lp_st == sfc_pkg::LP_DONE || lp_st == sfc_pkg::LP_DPOS ||
            lp_st == sfc_pkg::LP_DNEG;
    lp_fin = (lp_st == sfc_pkg::LP_DNEG && lp_val != 32'd0) ? 32'hFFFFFFFF : lp_val;
    if (firstnl_nxt) err = sfc_pkg::E_NO_CMD;
    else if (b != sfc_pkg::CH_NUL) err = sfc_pkg::E_NO_NULL;
    else if (!sawnl_nxt) err = sfc_pkg::E_NO_NL;
    else if (!dblnl_nxt) err = sfc_pkg::E_NO_BODYNL;
    else begin
      omask = seen_nxt;
      if (ph_nxt == sfc_pkg::PH_DEAD) err = lerr_nxt;
      else if (ph_nxt == sfc_pkg::PH_NAME) err = sfc_pkg::E_NO_HVAL;
      else if (ph_nxt == sfc_pkg::PH_VFIRST || ph_nxt == sfc_pkg::PH_VALUE)
        err = sfc_pkg::E_NO_LASTNL;
      else if (ph_nxt != sfc_pkg::PH_BODY) err = sfc_pkg::E_NO_BODYNL;
      else begin
        if (!seen_nxt[sfc_pkg::HDR_CL]) begin
          if (early_nxt) err = sfc_pkg::E_JUNK;
        end else if (!lp_ok) err = sfc_pkg::E_BAD_LEN;
        else if (lp_fin != {16'd0, body_nxt}) err = sfc_pkg::E_LEN_MISM;
        if (err == sfc_pkg::E_OK && (sfc_pkg::required_mask(cmd_nxt) & ~seen_nxt) != '0)
          err = sfc_pkg::E_MISS_REQ;
        if (err == sfc_pkg::E_OK || err >= sfc_pkg::E_BAD_LEN) olen = body_nxt;
      end
    end
  end

  // length converter sees the byte after this cycle's feed, so results use its
  // registered state at the final byte, which reflects bytes before it
  sfc_lenconv u_len (
    .clk, .rst_n,
    .step(lp_step), .clear(frame_end), .start(lp_start && acc_in && !in_empty_frame),
    .data_byte(b), .state_o(lp_st), .value_o(lp_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || frame_end) begin
      ph_r <= sfc_pkg::PH_CMD; idx_r <= '0; body_r <= '0;
      prevnl_r <= 1'b0; sawnl_r <= 1'b0; dblnl_r <= 1'b0; firstnl_r <= 1'b0;
      early_r <= 1'b0; cand_r <= {4'd0, {NC{1'b1}}}; pos_r <= '0;
      cmd_r <= '0; lerr_r <= '0; seen_r <= '0;
    end else if (acc_in) begin
      ph_r <= ph_nxt; idx_r <= idx_nxt; body_r <= body_nxt;
      prevnl_r <= prevnl_nxt; sawnl_r <= sawnl_nxt; dblnl_r <= dblnl_nxt;
      firstnl_r <= firstnl_nxt; early_r <= early_nxt; cand_r <= cand_nxt;
      pos_r <= pos_nxt; cmd_r <= cmd_nxt; lerr_r <= lerr_nxt; seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (frame_end) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      if (in_empty_frame) begin
        oerr_r <= sfc_pkg::E_NO_DATA; ocmd_r <= '0; omask_r <= '0; olen_r <= '0;
      end else begin
        oerr_r <= err;
        ocmd_r <= (err >= sfc_pkg::E_NO_DATA && err <= sfc_pkg::E_NO_BODYNL &&
                   omask == '0 && !dblnl_nxt) ? 4'd0 :
                  ((omask == '0 && err != sfc_pkg::E_OK && !(dblnl_nxt && sawnl_nxt &&
                   !firstnl_nxt && b == sfc_pkg::CH_NUL)) ? 4'd0 : cmd_nxt);
        omask_r <= omask; olen_r <= olen;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_error_code = oerr_r;
  assign out_command_code = ocmd_r;
  assign out_header_mask = omask_r;
  assign out_body_length = olen_r;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_error_code))
    else $error("verdict dropped while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && in_empty_frame |=> out_valid && out_error_code == sfc_pkg::E_NO_DATA)
    else $error("empty frame verdict wrong");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_body_length != 16'd0 |->
    (out_error_code == sfc_pkg::E_OK || out_error_code >= sfc_pkg::E_BAD_LEN))
    else $error("body length on line error");
`endif
endmodule
